### rtl/core/cdpi_pkg.sv
package cdpi_pkg;

  localparam int TIME_BITS_DEFAULT = 32;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GEAR_FRAME_ID    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_FRAME_ID   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WARNING_FRAME_ID = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GEAR_CODE_DRIVE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_GEAR_CODE_REV    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_FRESH_WINDOW     = 3'd5;

  // configuration reset values
  localparam logic [10:0] RST_GEAR_FRAME_ID    = 11'd280;
  localparam logic [10:0] RST_DRIVE_FRAME_ID   = 11'd646;
  localparam logic [10:0] RST_WARNING_FRAME_ID = 11'd785;
  localparam logic [2:0]  RST_GEAR_CODE_DRIVE  = 3'd4;
  localparam logic [2:0]  RST_GEAR_CODE_REV    = 3'd2;
  localparam logic [15:0] RST_FRESH_WINDOW     = 16'd1000;

  // frame length must exceed these to carry the given byte
  localparam logic [3:0] LEN_HAS_BYTE1 = 4'd1;
  localparam logic [3:0] LEN_HAS_BYTE2 = 4'd2;
  localparam logic [3:0] LEN_HAS_BYTE3 = 4'd3;

  localparam logic CMD_OBSERVE = 1'b0;

  // verdict codes: codes 1 to 8 in priority order, OK when none of them applies
  localparam logic [3:0] VERDICT_OK          = 4'd0;
  localparam logic [3:0] VERDICT_UPDATE      = 4'd1;
  localparam logic [3:0] VERDICT_BUS_QUIET   = 4'd2;
  localparam logic [3:0] VERDICT_NO_GEAR     = 4'd3;
  localparam logic [3:0] VERDICT_GEAR_STALE  = 4'd4;
  localparam logic [3:0] VERDICT_NOT_DR      = 4'd5;
  localparam logic [3:0] VERDICT_NO_BELT     = 4'd6;
  localparam logic [3:0] VERDICT_BELT_STALE  = 4'd7;
  localparam logic [3:0] VERDICT_UNLATCHED   = 4'd8;

  typedef struct packed {
    logic        cmd;
    logic [10:0] frame_id;
    logic [3:0]  frame_len;
    logic [7:0]  data_byte1;
    logic [7:0]  data_byte2;
    logic [7:0]  data_byte3;
    logic [31:0] now_ms;
    logic        update_in_progress;
    logic        bus_quiet;
    logic        assist_enabled;
    logic        mode_active;
  } cdpi_in_t;

  typedef struct packed {
    logic [3:0] verdict;
    logic       supervised;
    logic       allows;
    logic       floor_autonomous;
    logic [2:0] gear_now;
    logic [2:0] cruise_now;
    logic       belt_latched;
    logic       left_blink;
    logic       right_blink;
    logic       door_open;
  } cdpi_out_t;

  typedef struct packed {
    logic [10:0] gear_frame_id;
    logic [10:0] drive_state_frame_id;
    logic [10:0] warning_frame_id;
    logic [2:0]  gear_code_drive;
    logic [2:0]  gear_code_reverse;
    logic [15:0] fresh_window_ms;
  } cdpi_cfg_t;

  // decoded signal state, without the time stamps
  typedef struct packed {
    logic [2:0] gear;
    logic       gear_valid;
    logic [2:0] cruise;
    logic       belt;
    logic       belt_valid;
    logic [2:0] blink_door;  // bit0 left, bit1 right, bit2 door
  } cdpi_sig_t;

endpackage

### rtl/core/can_driver_presence_interlock_core.sv
// Driver-presence interlock: each input beat carries either a CAN frame to
// observe (gear, cruise state and warning frames, matched by configured
// identifier and length) or a plain evaluation request, plus the current
// millisecond time. Every input beat yields exactly one result beat with a
// prioritized verdict, the supervised and allow flags, the floor mode and the
// last decoded signals. One beat is accepted per cycle unless out_ready stalls
// a full result register while the input register is full; a beat goes from the
// input register through the decode, age compares and priority chain into the
// result register. Stamps and ages are TIME_BITS wide and wrap modulo 2^TIME_BITS.
// The user is to write configuration through the cfg port only while the block is idle; the block does not enforce it.
module can_driver_presence_interlock_core
  import cdpi_pkg::*;
#(
  parameter int TIME_BITS = TIME_BITS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  cdpi_in_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output cdpi_out_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic                 s1_valid_r;
  cdpi_in_t             s1_data_r;
  logic                 out_valid_r;
  cdpi_out_t            out_data_r;

  logic                 out_free, advance;
  logic [TIME_BITS-1:0] now_t;
  cdpi_cfg_t            cfg;
  cdpi_sig_t            sig_nxt;
  logic [TIME_BITS-1:0] gear_time_nxt, belt_time_nxt;
  cdpi_out_t            res;

  assign out_free  = !out_valid_r || out_ready;
  assign advance   = s1_valid_r && out_free;
  assign in_ready  = !s1_valid_r || out_free;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign now_t     = TIME_BITS'(s1_data_r.now_ms);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= res;
    end
  end

  cdpi_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  cdpi_signal_state #(.TIME_BITS(TIME_BITS)) u_state (
    .clk           (clk),
    .rst_n         (rst_n),
    .item          (s1_data_r),
    .advance       (advance),
    .cfg           (cfg),
    .now_t         (now_t),
    .sig_nxt       (sig_nxt),
    .gear_time_nxt (gear_time_nxt),
    .belt_time_nxt (belt_time_nxt)
  );

  cdpi_judge #(.TIME_BITS(TIME_BITS)) u_judge (
    .item      (s1_data_r),
    .cfg       (cfg),
    .sig       (sig_nxt),
    .gear_time (gear_time_nxt),
    .belt_time (belt_time_nxt),
    .now_t     (now_t),
    .res       (res)
  );

  // a beat leaving the input register always lands in the result register
  a_advance_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("input register moved without filling result register");

  // an empty input register never blocks the input side
  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> in_ready)
    else $error("input stalled with empty input register");

  a_supervised_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.supervised == (out_data_r.verdict == VERDICT_OK)))
    else $error("supervised flag disagrees with verdict");

  a_allows_implies: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.allows |->
      out_data_r.supervised && out_data_r.floor_autonomous)
    else $error("allow flag set without supervision or enable");

  a_verdict_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_data_r.verdict <= VERDICT_UNLATCHED)
    else $error("verdict code out of range");

endmodule

### rtl/core/cdpi_cfg_regs.sv
module cdpi_cfg_regs
  import cdpi_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cdpi_cfg_t             cfg
);

  cdpi_cfg_t cfg_r;
  logic      wr_en;

  assign cfg_ready = 1'b1;
  assign wr_en     = cfg_valid && cfg_ready;
  assign cfg       = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gear_frame_id        <= RST_GEAR_FRAME_ID;
      cfg_r.drive_state_frame_id <= RST_DRIVE_FRAME_ID;
      cfg_r.warning_frame_id     <= RST_WARNING_FRAME_ID;
      cfg_r.gear_code_drive      <= RST_GEAR_CODE_DRIVE;
      cfg_r.gear_code_reverse    <= RST_GEAR_CODE_REV;
      cfg_r.fresh_window_ms      <= RST_FRESH_WINDOW;
    end else if (wr_en) begin
      case (cfg_index)
        CFG_GEAR_FRAME_ID:    cfg_r.gear_frame_id        <= cfg_data[10:0];
        CFG_DRIVE_FRAME_ID:   cfg_r.drive_state_frame_id <= cfg_data[10:0];
        CFG_WARNING_FRAME_ID: cfg_r.warning_frame_id     <= cfg_data[10:0];
        CFG_GEAR_CODE_DRIVE:  cfg_r.gear_code_drive      <= cfg_data[2:0];
        CFG_GEAR_CODE_REV:    cfg_r.gear_code_reverse    <= cfg_data[2:0];
        CFG_FRESH_WINDOW:     cfg_r.fresh_window_ms      <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

### rtl/core/cdpi_signal_state.sv
module cdpi_signal_state
  import cdpi_pkg::*;
#(
  parameter int TIME_BITS = TIME_BITS_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cdpi_in_t             item,
  input  logic                 advance,
  input  cdpi_cfg_t            cfg,
  input  logic [TIME_BITS-1:0] now_t,
  output cdpi_sig_t            sig_nxt,
  output logic [TIME_BITS-1:0] gear_time_nxt,
  output logic [TIME_BITS-1:0] belt_time_nxt
);

  cdpi_sig_t            sig_r;
  logic [TIME_BITS-1:0] gear_time_r;
  logic [TIME_BITS-1:0] belt_time_r;

  logic observe;
  logic hit_gear, hit_drive, hit_warn;

  assign observe   = item.cmd == CMD_OBSERVE;
  assign hit_gear  = observe && item.frame_id == cfg.gear_frame_id
                     && item.frame_len > LEN_HAS_BYTE2;
  assign hit_drive = observe && item.frame_id == cfg.drive_state_frame_id
                     && item.frame_len > LEN_HAS_BYTE1;
  assign hit_warn  = observe && item.frame_id == cfg.warning_frame_id
                     && item.frame_len > LEN_HAS_BYTE1;

  always_comb begin
    sig_nxt       = sig_r;
    gear_time_nxt = gear_time_r;
    belt_time_nxt = belt_time_r;
    if (hit_gear) begin
      sig_nxt.gear       = item.data_byte2[7:5];
      sig_nxt.gear_valid = 1'b1;
      gear_time_nxt      = now_t;
    end
    if (hit_drive) begin
      sig_nxt.cruise = item.data_byte1[6:4];
    end
    if (hit_warn) begin
      sig_nxt.belt       = item.data_byte1[5];
      sig_nxt.belt_valid = 1'b1;
      belt_time_nxt      = now_t;
      // blinkers and door only when the frame carries their bytes
      if (item.frame_len > LEN_HAS_BYTE2) begin
        sig_nxt.blink_door[0] = item.data_byte2[6];
        sig_nxt.blink_door[1] = item.data_byte2[7];
      end
      if (item.frame_len > LEN_HAS_BYTE3) begin
        sig_nxt.blink_door[2] = item.data_byte3[4];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sig_r       <= '0;
      gear_time_r <= '0;
      belt_time_r <= '0;
    end else if (advance) begin
      sig_r       <= sig_nxt;
      gear_time_r <= gear_time_nxt;
      belt_time_r <= belt_time_nxt;
    end
  end

endmodule

### rtl/core/cdpi_judge.sv
module cdpi_judge
  import cdpi_pkg::*;
#(
  parameter int TIME_BITS = TIME_BITS_DEFAULT
) (
  input  cdpi_in_t             item,
  input  cdpi_cfg_t            cfg,
  input  cdpi_sig_t            sig,
  input  logic [TIME_BITS-1:0] gear_time,
  input  logic [TIME_BITS-1:0] belt_time,
  input  logic [TIME_BITS-1:0] now_t,
  output cdpi_out_t            res
);

  logic [TIME_BITS-1:0] window;
  logic [TIME_BITS-1:0] gear_age, belt_age;
  logic                 gear_old, belt_old, gear_dr;
  logic [3:0]           verdict;
  logic                 sup;

  // wrap-safe ages: modular difference against the window
  assign window   = TIME_BITS'(cfg.fresh_window_ms);
  assign gear_age = now_t - gear_time;
  assign belt_age = now_t - belt_time;
  assign gear_old = gear_age >= window;
  assign belt_old = belt_age >= window;
  assign gear_dr  = sig.gear == cfg.gear_code_drive
                    || sig.gear == cfg.gear_code_reverse;

  always_comb begin
    if (item.update_in_progress)  verdict = VERDICT_UPDATE;
    else if (item.bus_quiet)      verdict = VERDICT_BUS_QUIET;
    else if (!sig.gear_valid)     verdict = VERDICT_NO_GEAR;
    else if (gear_old)            verdict = VERDICT_GEAR_STALE;
    else if (!gear_dr)            verdict = VERDICT_NOT_DR;
    else if (!sig.belt_valid)     verdict = VERDICT_NO_BELT;
    else if (belt_old)            verdict = VERDICT_BELT_STALE;
    else if (!sig.belt)           verdict = VERDICT_UNLATCHED;
    else                          verdict = VERDICT_OK;
  end

  assign sup = verdict == VERDICT_OK;

  always_comb begin
    res.verdict          = verdict;
    res.supervised       = sup;
    res.allows           = item.assist_enabled && item.mode_active && sup;
    res.floor_autonomous = item.assist_enabled;
    res.gear_now         = sig.gear;
    res.cruise_now       = sig.cruise;
    res.belt_latched     = sig.belt;
    res.left_blink       = sig.blink_door[0];
    res.right_blink      = sig.blink_door[1];
    res.door_open        = sig.blink_door[2];
  end

endmodule
